### rtl/circular_scroll_from_motion_core_macros.svh
// Assertion macros shared by the rotary scroll RTL.
// Depends on nothing; files that check their own logic include this header.
`ifndef CIRCULAR_SCROLL_FROM_MOTION_CORE_MACROS_SVH
`define CIRCULAR_SCROLL_FROM_MOTION_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Concurrent check on an explicit clock and active-low reset.
`define CSM_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Concurrent check on the house clock and reset names.
`define CSM_ASSERT(label, prop, msg) \
    `CSM_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)
`else
`define CSM_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define CSM_ASSERT(label, prop, msg)
`endif
`endif

### rtl/csm_pkg.sv
// Shared widths, constants, state codes and control types of the rotary scroll core.
// Depends on nothing; the serial units and the top level refer to it by scoped names.
`timescale 1ns / 1ps

package csm_pkg;

    // Field and datapath widths.
    localparam int FIELD_W  = 11;  // signed motion delta
    localparam int MAG_W    = 10;  // magnitude of a saturated delta
    localparam int SUM_W    = 11;  // |dx| + |dy|
    localparam int SQ_W     = 21;  // dx*dx + dy*dy
    localparam int DZ_W     = 22;  // dead zone register
    localparam int GAIN_W   = 6;   // scroll gain register
    localparam int Q_W      = 11;  // quotient 0..1024
    localparam int REM_W    = 12;  // divider partial remainder
    localparam int ANGLE_W  = 13;  // pseudo-angle 0..4095
    localparam int DELTA_W  = 14;  // raw signed angle change
    localparam int DMAG_W   = 12;  // magnitude of wrapped angle change, 0..2048
    localparam int PROD_W   = 17;  // |delta| * gain
    localparam int SCROLL_W = 7;   // scroll magnitude 0..126
    localparam int CNT_W    = 4;
    localparam int TDATA_W  = 24;
    localparam int CFG_IDX_W = 1;

    // Step counts of the serial units.
    localparam int CALC_STEPS = 11;  // divider needs 11, squarer 10
    localparam int MUL_STEPS  = GAIN_W;
    localparam int GAIN_SHIFT = 10;

    // Constants of the angle arithmetic.
    localparam logic signed [FIELD_W-1:0] DELTA_MIN_RAW = -11'sd1024;
    localparam logic signed [FIELD_W-1:0] DELTA_SAT     = -11'sd1023;
    localparam logic [ANGLE_W-1:0]        ANGLE_HALF    = 13'd2048;
    localparam logic [ANGLE_W-1:0]        ANGLE_FULL    = 13'd4096;
    localparam logic signed [DELTA_W-1:0] WRAP_HALF     = 14'sd2048;
    localparam logic signed [DELTA_W-1:0] WRAP_FULL     = 14'sd4096;
    localparam logic signed [FIELD_W-1:0] SCROLL_MAX    = 11'sd126;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 1'b1;
    localparam logic [DZ_W-1:0]      DZ_RESET      = 22'd25;
    localparam logic [GAIN_W-1:0]    GAIN_RESET    = 6'd10;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_ANG,
        S_MUL,
        S_DONE
    } t_state;

    // Control of one serial unit: load operands, or advance one digit.
    typedef struct packed {
        logic load;
        logic step;
    } t_unit_ctl;

endpackage

### rtl/csm_sqsum.sv
// Bit-serial sum of squares dx*dx + dy*dy, one multiplier bit per cycle.
// Depends on csm_pkg for widths and the unit control type.
`timescale 1ns / 1ps

module csm_sqsum (
    input  logic                          i_clk,
    input  csm_pkg::t_unit_ctl            i_ctl,
    input  logic [csm_pkg::MAG_W-1:0]     i_ax,
    input  logic [csm_pkg::MAG_W-1:0]     i_ay,
    output logic [csm_pkg::SQ_W-1:0]      o_sum
);

    logic [csm_pkg::MAG_W-1:0] r_mx;
    logic [csm_pkg::MAG_W-1:0] r_my;
    logic [csm_pkg::SQ_W-1:0]  r_cx;
    logic [csm_pkg::SQ_W-1:0]  r_cy;
    logic [csm_pkg::SQ_W-1:0]  r_acc;
    logic [csm_pkg::SQ_W-1:0]  n_acc;

    // Add the shifted multiplicands selected by the current multiplier bits.
    always_comb begin
        n_acc = r_acc + (r_mx[0] ? r_cx : '0) + (r_my[0] ? r_cy : '0);
    end

    // Multipliers shift right, multiplicands shift left, one bit a cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mx  <= i_ax;
            r_my  <= i_ay;
            r_cx  <= csm_pkg::SQ_W'(i_ax);
            r_cy  <= csm_pkg::SQ_W'(i_ay);
            r_acc <= '0;
        end else if (i_ctl.step) begin
            r_mx  <= r_mx >> 1;
            r_my  <= r_my >> 1;
            r_cx  <= r_cx << 1;
            r_cy  <= r_cy << 1;
            r_acc <= n_acc;
        end
    end

    assign o_sum = r_acc;

endmodule

### rtl/csm_div.sv
// Restoring divider giving floor(num * 1024 / den), one quotient bit per cycle.
// Depends on csm_pkg for widths and the unit control type.
`timescale 1ns / 1ps

module csm_div (
    input  logic                          i_clk,
    input  csm_pkg::t_unit_ctl            i_ctl,
    input  logic [csm_pkg::MAG_W-1:0]     i_num,
    input  logic [csm_pkg::SUM_W-1:0]     i_den,
    output logic [csm_pkg::Q_W-1:0]       o_quot
);

    logic [csm_pkg::REM_W-1:0] r_rem;
    logic [csm_pkg::SUM_W-1:0] r_den;
    logic [csm_pkg::Q_W-1:0]   r_quot;
    logic                      n_bit;
    logic [csm_pkg::REM_W-1:0] n_part;

    // Trial subtract; the remainder is shifted after each decision, so the
    // first step weighs the numerator against the divisor at 1024 times.
    always_comb begin
        n_bit  = r_rem >= csm_pkg::REM_W'(r_den);
        n_part = n_bit ? (r_rem - csm_pkg::REM_W'(r_den)) : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem  <= csm_pkg::REM_W'(i_num);
            r_den  <= i_den;
            r_quot <= '0;
        end else if (i_ctl.step) begin
            r_rem  <= {n_part[csm_pkg::REM_W-2:0], 1'b0};
            r_quot <= {r_quot[csm_pkg::Q_W-2:0], n_bit};
        end
    end

    assign o_quot = r_quot;

endmodule

### rtl/csm_mul.sv
// Bit-serial product |angle change| * gain, one gain bit per cycle.
// Depends on csm_pkg for widths and the unit control type.
`timescale 1ns / 1ps

module csm_mul (
    input  logic                          i_clk,
    input  csm_pkg::t_unit_ctl            i_ctl,
    input  logic [csm_pkg::DMAG_W-1:0]    i_mcand,
    input  logic [csm_pkg::GAIN_W-1:0]    i_gain,
    output logic [csm_pkg::PROD_W-1:0]    o_prod
);

    logic [csm_pkg::PROD_W-1:0] r_mc;
    logic [csm_pkg::GAIN_W-1:0] r_mg;
    logic [csm_pkg::PROD_W-1:0] r_prod;

    // Shift-and-add over the gain bits, lowest first.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mc   <= csm_pkg::PROD_W'(i_mcand);
            r_mg   <= i_gain;
            r_prod <= '0;
        end else if (i_ctl.step) begin
            r_mc <= r_mc << 1;
            r_mg <= r_mg >> 1;
            if (r_mg[0]) begin
                r_prod <= r_prod + r_mc;
            end
        end
    end

    assign o_prod = r_prod;

endmodule

### rtl/circular_scroll_from_motion_core.sv
// Rotary scroll core: turns circular pointer motion into vertical scroll words.
// Top level; uses csm_pkg, csm_sqsum, csm_div, csm_mul and the assertion macros.
//
// Usage:
//  - Input stream s_axis: tdata carries move_x and move_y, tuser flags a
//    pointing event. Output stream m_axis: tdata carries out_x and out_y,
//    tuser flags an event that was converted into a scroll.
//  - Every input word gives exactly one output word, in order.
//  - After acceptance, a word passes through 11 steps of the serial divider for
//    the pseudo-angle (the serial squarer runs beside it), the angle state,
//    6 steps of the serial gain multiplier and a state that loads the result
//    into the output register. Only then does the core return to idle and
//    accept the next word; it takes no new word while one is under work.
//  - A finished word waits in the output register; the core accepts and
//    starts the next word meanwhile and holds its own result until the
//    output register frees up. A stalled receiver therefore stops input
//    acceptance only after one more word.
//  - Configuration writes (dead zone, gain) take effect at once and are to
//    be made only while the core is idle.
//  - Reset clears tracking, the stored angle and the output; dead zone 25, gain 10.
`timescale 1ns / 1ps
`include "circular_scroll_from_motion_core_macros.svh"

module circular_scroll_from_motion_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [csm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [csm_pkg::DZ_W-1:0]          i_cfg_data,
    // Input stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [csm_pkg::TDATA_W-1:0]       s_axis_tdata,  // [10:0] move_x, [21:11] move_y
    input  logic                              s_axis_tuser,  // [0] is_pointing
    // Output stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [csm_pkg::TDATA_W-1:0]       m_axis_tdata,  // [10:0] out_x, [21:11] out_y
    output logic                              m_axis_tuser   // [0] converted
);

    localparam int FW = csm_pkg::FIELD_W;

    // Sequencer.
    csm_pkg::t_state           r_state;
    csm_pkg::t_state           n_state;
    logic [csm_pkg::CNT_W-1:0] r_cnt;
    logic [csm_pkg::CNT_W-1:0] n_cnt;
    logic                      w_accept;
    logic                      w_out_load;
    csm_pkg::t_unit_ctl        w_calc_ctl;
    csm_pkg::t_unit_ctl        w_mul_ctl;

    // Configuration and tracking state.
    logic [csm_pkg::DZ_W-1:0]    r_dz;
    logic [csm_pkg::GAIN_W-1:0]  r_gain;
    logic                        r_tracking;
    logic [csm_pkg::ANGLE_W-1:0] r_last;

    // Word under work.
    logic                 r_ptr;
    logic signed [FW-1:0] r_dx;
    logic signed [FW-1:0] r_dy;
    logic                 r_zero;
    logic                 r_conv;
    logic                 r_neg;

    // Input saturation and magnitudes.
    logic signed [FW-1:0]        w_in_x;
    logic signed [FW-1:0]        w_in_y;
    logic signed [FW-1:0]        w_sat_x;
    logic signed [FW-1:0]        w_sat_y;
    logic signed [FW-1:0]        w_neg_x;
    logic signed [FW-1:0]        w_neg_y;
    logic [csm_pkg::MAG_W-1:0]   w_ax;
    logic [csm_pkg::MAG_W-1:0]   w_ay;
    logic [csm_pkg::SUM_W-1:0]   w_sum;

    // Serial unit results and angle logic.
    logic [csm_pkg::SQ_W-1:0]    w_sq;
    logic [csm_pkg::Q_W-1:0]     w_quot;
    logic [csm_pkg::PROD_W-1:0]  w_prod;
    logic [csm_pkg::ANGLE_W-1:0] w_r;
    logic [csm_pkg::ANGLE_W-1:0] w_angle;
    logic signed [csm_pkg::DELTA_W-1:0] w_raw;
    logic signed [csm_pkg::DELTA_W-1:0] w_wrap;
    logic signed [csm_pkg::DELTA_W-1:0] w_wrap_neg;
    logic [csm_pkg::DMAG_W-1:0]  w_dmag;
    logic                        w_below;
    logic [csm_pkg::SCROLL_W-1:0] w_scroll;
    logic signed [FW-1:0]        w_scroll_s;

    // Output register.
    logic                 r_m_valid;
    logic                 r_m_user;
    logic signed [FW-1:0] r_m_x;
    logic signed [FW-1:0] r_m_y;

    // Saturate -1024 to -1023 and take magnitudes.
    always_comb begin
        w_in_x  = s_axis_tdata[FW-1:0];
        w_in_y  = s_axis_tdata[2*FW-1:FW];
        w_sat_x = (w_in_x == csm_pkg::DELTA_MIN_RAW) ? csm_pkg::DELTA_SAT : w_in_x;
        w_sat_y = (w_in_y == csm_pkg::DELTA_MIN_RAW) ? csm_pkg::DELTA_SAT : w_in_y;
        w_neg_x = -w_sat_x;
        w_neg_y = -w_sat_y;
        w_ax    = w_sat_x[FW-1] ? w_neg_x[csm_pkg::MAG_W-1:0] : w_sat_x[csm_pkg::MAG_W-1:0];
        w_ay    = w_sat_y[FW-1] ? w_neg_y[csm_pkg::MAG_W-1:0] : w_sat_y[csm_pkg::MAG_W-1:0];
        w_sum   = csm_pkg::SUM_W'(w_ax) + csm_pkg::SUM_W'(w_ay);
    end

    // Serial units.
    csm_sqsum u_sqsum (
        .i_clk (i_clk),
        .i_ctl (w_calc_ctl),
        .i_ax  (w_ax),
        .i_ay  (w_ay),
        .o_sum (w_sq)
    );

    csm_div u_div (
        .i_clk  (i_clk),
        .i_ctl  (w_calc_ctl),
        .i_num  (w_ay),
        .i_den  (w_sum),
        .o_quot (w_quot)
    );

    csm_mul u_mul (
        .i_clk   (i_clk),
        .i_ctl   (w_mul_ctl),
        .i_mcand (w_dmag),
        .i_gain  (r_gain),
        .o_prod  (w_prod)
    );

    // Quadrant fold, angle change with wrap, dead zone compare.
    always_comb begin
        w_r = csm_pkg::ANGLE_W'(w_quot);
        case ({r_dx[FW-1], r_dy[FW-1]})
            2'b00:   w_angle = w_r;
            2'b10:   w_angle = csm_pkg::ANGLE_HALF - w_r;
            2'b11:   w_angle = csm_pkg::ANGLE_HALF + w_r;
            default: w_angle = csm_pkg::ANGLE_FULL - w_r;
        endcase
        if (r_zero) begin
            w_angle = '0;
        end
        w_raw = $signed({1'b0, w_angle}) - $signed({1'b0, r_last});
        if (w_raw > csm_pkg::WRAP_HALF) begin
            w_wrap = w_raw - csm_pkg::WRAP_FULL;
        end else if (w_raw < -csm_pkg::WRAP_HALF) begin
            w_wrap = w_raw + csm_pkg::WRAP_FULL;
        end else begin
            w_wrap = w_raw;
        end
        w_wrap_neg = -w_wrap;
        w_dmag     = w_wrap[csm_pkg::DELTA_W-1] ? w_wrap_neg[csm_pkg::DMAG_W-1:0]
                                                : w_wrap[csm_pkg::DMAG_W-1:0];
        w_below    = csm_pkg::DZ_W'(w_sq) < r_dz;
    end

    // Scroll amount, truncated toward zero by scaling the magnitude.
    always_comb begin
        w_scroll   = w_prod[csm_pkg::GAIN_SHIFT +: csm_pkg::SCROLL_W];
        w_scroll_s = r_neg ? -$signed(FW'(w_scroll)) : $signed(FW'(w_scroll));
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csm_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and unit control.
    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        s_axis_tready   = 1'b0;
        w_out_load      = 1'b0;
        w_calc_ctl.load = 1'b0;
        w_calc_ctl.step = 1'b0;
        w_mul_ctl.load  = 1'b0;
        w_mul_ctl.step  = 1'b0;
        unique case (r_state)
            csm_pkg::S_IDLE: begin
                s_axis_tready   = i_rst_n;
                w_calc_ctl.load = s_axis_tvalid;
                if (s_axis_tvalid) begin
                    n_state = csm_pkg::S_CALC;
                    n_cnt   = '0;
                end
            end
            csm_pkg::S_CALC: begin
                w_calc_ctl.step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == csm_pkg::CNT_W'(csm_pkg::CALC_STEPS - 1)) begin
                    n_state = csm_pkg::S_ANG;
                    n_cnt   = '0;
                end
            end
            csm_pkg::S_ANG: begin
                w_mul_ctl.load = 1'b1;
                n_state        = csm_pkg::S_MUL;
            end
            csm_pkg::S_MUL: begin
                w_mul_ctl.step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == csm_pkg::CNT_W'(csm_pkg::MUL_STEPS - 1)) begin
                    n_state = csm_pkg::S_DONE;
                    n_cnt   = '0;
                end
            end
            csm_pkg::S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    w_out_load = 1'b1;
                    n_state    = csm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = csm_pkg::S_IDLE;
            end
        endcase
    end

    assign w_accept = s_axis_tvalid && s_axis_tready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz   <= csm_pkg::DZ_RESET;
            r_gain <= csm_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                csm_pkg::CFG_DEAD_ZONE: r_dz   <= i_cfg_data;
                csm_pkg::CFG_GAIN:      r_gain <= i_cfg_data[csm_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Tracking state, updated once per pointing word after the angle is known.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracking <= 1'b0;
            r_last     <= '0;
        end else if (r_state == csm_pkg::S_ANG && r_ptr) begin
            if (w_below) begin
                r_tracking <= 1'b0;
            end else begin
                r_tracking <= 1'b1;
                r_last     <= w_angle;
            end
        end
    end

    // Word under work: captured at acceptance, decision made after the angle.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ptr  <= s_axis_tuser;
            r_dx   <= w_sat_x;
            r_dy   <= w_sat_y;
            r_zero <= (w_sum == '0);
        end
        if (r_state == csm_pkg::S_ANG) begin
            r_conv <= r_ptr && !w_below && r_tracking;
            r_neg  <= w_wrap[csm_pkg::DELTA_W-1];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_user <= r_conv;
            r_m_x    <= r_conv ? '0 : r_dx;
            r_m_y    <= r_conv ? w_scroll_s : r_dy;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tdata  = {(csm_pkg::TDATA_W - 2 * FW)'(0), r_m_y, r_m_x};

    // Checks on the sequencing and on converted words.
    `CSM_ASSERT(a_busy_after_accept, w_accept |=> !s_axis_tready, "input accepted while busy")
    `CSM_ASSERT(a_load_from_done, $rose(r_m_valid) |-> $past(r_state) == csm_pkg::S_DONE, "result loaded outside completion")
    `CSM_ASSERT(a_conv_zero_x, (r_m_valid && r_m_user) |-> r_m_x == '0, "converted word has nonzero x")
    `CSM_ASSERT(a_scroll_bound, (r_m_valid && r_m_user) |-> (r_m_y <= csm_pkg::SCROLL_MAX && r_m_y >= -csm_pkg::SCROLL_MAX), "scroll amount out of range")

endmodule

### test/circular_scroll_from_motion_core_checker.sv
// Checker for the rotary scroll core: predicts every output word and compares it.
// Depends on csm_pkg; watches the configuration port and both streams of the core.
`timescale 1ns / 1ps

module circular_scroll_from_motion_core_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [csm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [csm_pkg::DZ_W-1:0]          i_cfg_data,
    input  logic                              i_s_axis_tvalid,
    input  logic                              i_s_axis_tready,
    input  logic [csm_pkg::TDATA_W-1:0]       i_s_axis_tdata,  // [10:0] move_x, [21:11] move_y
    input  logic                              i_s_axis_tuser,  // [0] is_pointing
    input  logic                              i_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [csm_pkg::TDATA_W-1:0]       i_m_axis_tdata,  // [10:0] out_x, [21:11] out_y
    input  logic                              i_m_axis_tuser,  // [0] converted
    output int                                o_mismatches,
    output int                                o_pending,
    output int                                o_scroll_words
);

    localparam int DELTA_LIMIT   = 1023;
    localparam int QUARTER_TURN  = 1024;
    localparam int HALF_TURN     = 2048;
    localparam int FULL_TURN     = 4096;
    localparam int GAIN_DIVISOR  = 1024;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic                                converted;
        logic signed [csm_pkg::FIELD_W-1:0]  out_x;
        logic signed [csm_pkg::FIELD_W-1:0]  out_y;
    } t_scroll_word;

    // Shadow copy of the core's registers and tracking state.
    logic [csm_pkg::DZ_W-1:0]    dead_zone;
    logic [csm_pkg::GAIN_W-1:0]  gain;
    logic                        tracking;
    logic [csm_pkg::ANGLE_W-1:0] last_angle;

    t_scroll_word pending_scroll_words[$];
    int           mismatches;
    int           scroll_words;
    int           words_out;

    // A raw delta of -1024 is pulled in to -1023.
    function automatic int clamp_delta(logic [csm_pkg::FIELD_W-1:0] raw);
        int v;
        v = int'($signed(raw));
        if (v < -DELTA_LIMIT) v = -DELTA_LIMIT;
        return v;
    endfunction

    // Diamond pseudo-angle, 0..4095 for a full turn; zero motion gives 0.
    function automatic int diamond_angle(int dx, int dy);
        int ax;
        int ay;
        int r;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax + ay == 0) return 0;
        r = (ay * QUARTER_TURN) / (ax + ay);
        if (dx >= 0 && dy >= 0) return r;
        if (dx < 0 && dy >= 0) return 2 * QUARTER_TURN - r;
        if (dx < 0) return 2 * QUARTER_TURN + r;
        return 4 * QUARTER_TURN - r;
    endfunction

    // Works out the output word for one accepted motion word and updates tracking.
    task automatic predict_scroll_word(input logic pointing,
                                       input logic [csm_pkg::FIELD_W-1:0] raw_x,
                                       input logic [csm_pkg::FIELD_W-1:0] raw_y,
                                       output t_scroll_word word);
        int dx;
        int dy;
        int mag;
        int angle;
        int turn;
        int prod;
        int amount;
        dx = clamp_delta(raw_x);
        dy = clamp_delta(raw_y);
        word.converted = 1'b0;
        word.out_x     = csm_pkg::FIELD_W'(dx);
        word.out_y     = csm_pkg::FIELD_W'(dy);
        if (!pointing) return;

        mag = dx * dx + dy * dy;
        if (mag < int'(dead_zone)) begin
            tracking = 1'b0;
            return;
        end

        angle = diamond_angle(dx, dy);
        if (!tracking) begin
            tracking   = 1'b1;
            last_angle = csm_pkg::ANGLE_W'(angle);
            return;
        end

        // Angle change wrapped into -2048..2048, both ends kept.
        turn = angle - int'(last_angle);
        if (turn > HALF_TURN) turn -= FULL_TURN;
        else if (turn < -HALF_TURN) turn += FULL_TURN;
        last_angle = csm_pkg::ANGLE_W'(angle);

        // Scale by the gain, truncating toward zero.
        prod = turn * int'(gain);
        if (prod < 0) amount = -((-prod) / GAIN_DIVISOR);
        else amount = prod / GAIN_DIVISOR;

        word.converted = 1'b1;
        word.out_x     = '0;
        word.out_y     = csm_pkg::FIELD_W'(amount);
    endtask

    // Watch both streams and the register port on every rising edge.
    always @(posedge i_clk) begin
        t_scroll_word expected;
        t_scroll_word actual;
        if (!i_rst_n) begin
            dead_zone  = csm_pkg::DZ_RESET;
            gain       = csm_pkg::GAIN_RESET;
            tracking   = 1'b0;
            last_angle = '0;
            pending_scroll_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    csm_pkg::CFG_DEAD_ZONE: dead_zone = i_cfg_data;
                    csm_pkg::CFG_GAIN:      gain = i_cfg_data[csm_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end

            // Compare an output word with the oldest prediction.
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                actual.converted = i_m_axis_tuser;
                actual.out_x     = i_m_axis_tdata[csm_pkg::FIELD_W-1:0];
                actual.out_y     = i_m_axis_tdata[2*csm_pkg::FIELD_W-1:csm_pkg::FIELD_W];
                words_out++;
                if (actual.converted) scroll_words++;
                if (pending_scroll_words.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("[%0t] output word %0d arrived with nothing predicted",
                                 $time, words_out);
                    mismatches++;
                end else begin
                    expected = pending_scroll_words.pop_front();
                    if (actual.converted != expected.converted
                            || actual.out_x != expected.out_x
                            || actual.out_y != expected.out_y) begin
                        if (mismatches < REPORT_LIMIT) begin
                            $display("[%0t] output word %0d: expected converted=%0b x=%0d y=%0d",
                                     $time, words_out, expected.converted, expected.out_x,
                                     expected.out_y);
                            $display("    got converted=%0b x=%0d y=%0d",
                                     actual.converted, actual.out_x, actual.out_y);
                        end
                        mismatches++;
                    end
                end
            end

            // Predict the word that an accepted input will produce.
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predict_scroll_word(i_s_axis_tuser,
                    i_s_axis_tdata[csm_pkg::FIELD_W-1:0],
                    i_s_axis_tdata[2*csm_pkg::FIELD_W-1:csm_pkg::FIELD_W], expected);
                pending_scroll_words.push_back(expected);
            end
        end
        o_mismatches   <= mismatches;
        o_pending      <= pending_scroll_words.size();
        o_scroll_words <= scroll_words;
    end

endmodule

### test/circular_scroll_from_motion_core_tb.sv
// Testbench top for the rotary scroll core: clock, reset, stimulus and verdict.
// Depends on csm_pkg, the core and circular_scroll_from_motion_core_checker.
`timescale 1ns / 1ps

module circular_scroll_from_motion_core_tb;

    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 24;
    localparam int LONG_HOLD      = 300;
    // Longest quiet stretch in a correct run is the long hold plus one word's latency.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int NUM_PHASES     = 8;
    localparam int QUARTER_TURN   = 1024;
    localparam int FULL_TURN      = 4096;
    localparam int PAD_W          = csm_pkg::TDATA_W - 2 * csm_pkg::FIELD_W;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [csm_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [csm_pkg::DZ_W-1:0]      i_cfg_data = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [csm_pkg::TDATA_W-1:0]   s_axis_tdata = '0;  // [10:0] move_x, [21:11] move_y
    logic                          s_axis_tuser = 1'b0;  // [0] is_pointing
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [csm_pkg::TDATA_W-1:0]   m_axis_tdata;  // [10:0] out_x, [21:11] out_y
    logic                          m_axis_tuser;  // [0] converted

    int   mismatches;
    int   results_pending;
    int   scroll_words;
    int   stall_pct = 0;
    int   gap_pct = 0;
    logic hold_req = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    int   words_sent = 0;
    int   settings_used = 0;

    // Circular sweep generator state.
    int   sweep_angle = 0;
    int   sweep_step = 64;
    int   sweep_radius = 600;

    always #4 i_clk = ~i_clk;

    circular_scroll_from_motion_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    circular_scroll_from_motion_core_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .o_mismatches    (mismatches),
        .o_pending       (results_pending),
        .o_scroll_words  (scroll_words)
    );

    // Receiver: random stalls, plus a long hold whenever the stimulus toggles hold_req.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
        end else if (hold_req != hold_seen) begin
            hold_seen     <= hold_req;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog on cycles in which no word moves on either stream.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one motion word, with an optional idle gap first, and wait for acceptance.
    task automatic send_motion(input logic pointing, input int x, input int y);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < gap_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pointing;
        s_axis_tdata  <= {{PAD_W{1'b0}}, csm_pkg::FIELD_W'(y), csm_pkg::FIELD_W'(x)};
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
    endtask

    // Stop offering and wait until every predicted word has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers on consecutive edges; the core is idle here.
    task automatic load_settings(input logic [csm_pkg::DZ_W-1:0] dead_zone,
                                 input logic [csm_pkg::GAIN_W-1:0] gain);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= csm_pkg::CFG_DEAD_ZONE;
        i_cfg_data <= dead_zone;
        @(posedge i_clk);
        i_cfg_idx  <= csm_pkg::CFG_GAIN;
        i_cfg_data <= {{(csm_pkg::DZ_W - csm_pkg::GAIN_W){1'b0}}, gain};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        settings_used++;
    endtask

    // Next point of a sweep around a diamond-shaped path; starts a new track now and then.
    task automatic sweep_point(output int x, output int y);
        int t;
        int u;
        int v;
        if ($urandom_range(0, 99) < 5) begin
            sweep_angle  = $urandom_range(0, FULL_TURN - 1);
            sweep_radius = $urandom_range(40, 1023);
            if ($urandom_range(0, 9) == 0) sweep_step = $urandom_range(1500, 2048);
            else sweep_step = $urandom_range(1, 400);
            if ($urandom_range(0, 1) == 1) sweep_step = -sweep_step;
        end
        sweep_angle = (sweep_angle + sweep_step + FULL_TURN) % FULL_TURN;
        t = sweep_angle % QUARTER_TURN;
        u = sweep_radius * (QUARTER_TURN - t) / QUARTER_TURN;
        v = sweep_radius * t / QUARTER_TURN;
        if (sweep_angle < QUARTER_TURN) begin
            x = u;
            y = v;
        end else if (sweep_angle < 2 * QUARTER_TURN) begin
            x = -v;
            y = u;
        end else if (sweep_angle < 3 * QUARTER_TURN) begin
            x = -u;
            y = -v;
        end else begin
            x = v;
            y = -u;
        end
    endtask

    initial begin
        int items;
        int kind;
        int x;
        int y;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with reset settings: dead zone 25, gain 10.
        send_motion(1'b0, -1024, 1023);   // not pointing, extremes pass through saturated
        send_motion(1'b1, 0, 0);          // zero motion below the dead zone
        send_motion(1'b1, 1023, 0);       // first event of a track, angle 0
        send_motion(1'b0, 5, -7);         // not pointing mid-track, state untouched
        send_motion(1'b1, 0, 1023);       // quarter turn
        send_motion(1'b1, -1023, 0);
        send_motion(1'b1, 0, -1024);      // saturated negative delta
        send_motion(1'b1, 1023, 0);       // wraps from -3072 to +1024
        send_motion(1'b1, -1023, 0);      // change of exactly +2048
        send_motion(1'b1, 1023, 0);       // change of exactly -2048
        send_motion(1'b1, -1024, -1024);  // wraps to a negative change
        send_motion(1'b1, -1023, -1);     // negative scroll truncated toward zero
        send_motion(1'b1, 3, 3);          // just below the dead zone, ends the track
        send_motion(1'b1, 3, 4);          // exactly at the dead zone, starts a track
        send_motion(1'b1, 1023, -1);      // angle near a full turn
        drain_results();

        // Dead zone off, highest gain.
        load_settings('0, '1);
        send_motion(1'b1, 0, 0);          // zero motion counts when the dead zone is 0
        send_motion(1'b1, 0, 1023);
        send_motion(1'b1, -1023, 1023);
        drain_results();

        // Dead zone above the largest sum of squares, zero gain: every motion falls inside the dead zone.
        load_settings(22'h200000, '0);
        send_motion(1'b1, 1023, 1023);
        send_motion(1'b1, -1023, -1023);
        send_motion(1'b1, 1023, -1024);

        // Random part: phases that differ in settings and handshake mix.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            case (phase)
                0: load_settings(22'd25, 6'd10);
                1: load_settings('0, '1);
                3: load_settings(csm_pkg::DZ_W'($urandom_range(0, 2097151)),
                                 csm_pkg::GAIN_W'($urandom_range(0, 63)));
                6: load_settings(22'd100, '0);
                default: load_settings(csm_pkg::DZ_W'($urandom_range(0, 2000)),
                                       csm_pkg::GAIN_W'($urandom_range(0, 63)));
            endcase
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct <= 0;  end
                1: begin gap_pct = 61; stall_pct <= 0;  end
                2: begin gap_pct = 0;  stall_pct <= 61; end
                default: begin gap_pct = 36; stall_pct <= 36; end
            endcase
            items = (phase == 3) ? 120 : 245;
            for (int n = 0; n < items; n++) begin
                // Back up the output while input keeps being offered.
                if (phase == 4 && n == 60) hold_req <= ~hold_req;
                // Let the core run dry once in the middle of a phase.
                if (phase == 5 && n == 120) drain_results();
                kind = $urandom_range(0, 99);
                if (kind < 60) begin
                    sweep_point(x, y);
                    send_motion(1'b1, x, y);
                end else if (kind < 72) begin
                    send_motion(1'b1, $urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4);
                end else if (kind < 84) begin
                    send_motion(1'b0, $urandom_range(0, 2047), $urandom_range(0, 2047));
                end else begin
                    send_motion(1'b1, $urandom_range(0, 2047), $urandom_range(0, 2047));
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d motion words under %0d register settings and four handshake mixes;",
                 words_sent, settings_used);
        $display("%0d of them came back as scroll words.", scroll_words);
        if (mismatches == 0 && results_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatched words, %0d predictions never answered",
                     mismatches, results_pending);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
